>>> src/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by ffba_ctrl and first_fit_block_allocator_core.
package ffba_pkg;

    localparam int MAX_BLOCKS   = 16;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_W       = 20;
    localparam int SIZE_W       = 16;
    localparam int HANDLE_W     = 4;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int HEAP_W       = ADDR_W + 1;
    localparam int END_W        = HEAP_W + 1;
    localparam int ENTRY_W      = SIZE_W + ADDR_W;

    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = {ADDR_W{1'b1}};

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK   = 3'd0,
        STAT_ZERO = 3'd1,
        STAT_FULL = 3'd2,
        STAT_HEAP = 3'd3,
        STAT_BADH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SEND
    } state_t;

    typedef struct packed {
        logic                command;
        logic [SIZE_W-1:0]   req_size;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] block_handle;
        logic [ADDR_W-1:0]   payload_addr;
        logic                reused;
    } rsp_t;

endpackage

>>> src/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ffba_ctrl.sv
// Allocator sequencer: block table scan, free bits, bump pointer, result build.
// Depends on ffba_pkg and ffba_ram (block size/base table).
module ffba_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  ffba_pkg::req_t         req,
    input  logic [ffba_pkg::ADDR_W-1:0] heap_limit,
    input  logic                   slot_free,
    output logic                   busy,
    output logic                   res_valid,
    output ffba_pkg::rsp_t         res
);
    import ffba_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [SIZE_W-1:0]   req_size_reg, req_size_next;
    rsp_t                res_reg, res_next;
    logic [MAX_BLOCKS-1:0] free_reg, free_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HEAP_W-1:0]   heap_top_reg, heap_top_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [SIZE_W-1:0]   rd_size;
    logic [ADDR_W-1:0]   rd_base;

    logic [IDX_W-1:0]    entry;
    logic                in_range;
    logic                hit;
    logic                miss;
    logic [END_W-1:0]    end_sum;
    logic                is_alloc;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_size   = ram_rdata[ENTRY_W-1 -: SIZE_W];
    assign rd_base   = ram_rdata[ADDR_W-1:0];
    assign ram_wdata = {req_size_reg, heap_top_reg[ADDR_W-1:0]};

    assign entry    = idx_reg[IDX_W-1:0];
    assign in_range = idx_reg < count_reg;
    assign hit      = in_range && free_reg[entry] && (rd_size >= req_size_reg);
    assign miss     = !in_range;
    assign end_sum  = END_W'(heap_top_reg) + END_W'(HEADER_BYTES) + END_W'(req_size_reg);
    assign is_alloc = (req.command == CMD_ALLOC) && (req.req_size != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = is_alloc ? S_SCAN : S_SEND;
                end
            end
            S_SCAN:
            begin
                if (hit || miss)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next      = idx_reg;
        req_size_next = req_size_reg;
        res_next      = res_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        heap_top_next = heap_top_reg;
        ram_we        = 1'b0;
        ram_raddr     = '0;
        busy          = 1'b1;
        res_valid     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (req_valid)
                begin
                    req_size_next = req.req_size;
                    idx_next      = '0;
                    res_next      = '{STAT_OK, '0, '0, 1'b0};
                    if (req.command == CMD_FREE)
                    begin
                        if (CNT_W'(req.handle) >= count_reg)
                        begin
                            res_next.status = STAT_BADH;
                        end
                        else
                        begin
                            free_next[req.handle[IDX_W-1:0]] = 1'b1;
                            res_next.block_handle = req.handle;
                        end
                    end
                    else if (req.req_size == '0)
                    begin
                        res_next.status = STAT_ZERO;
                    end
                end
            end
            S_SCAN:
            begin
                idx_next  = idx_reg + CNT_W'(1);
                ram_raddr = idx_next[IDX_W-1:0];
                if (hit)
                begin
                    free_next[entry]      = 1'b0;
                    res_next.block_handle = HANDLE_W'(entry);
                    res_next.payload_addr = rd_base + ADDR_W'(HEADER_BYTES);
                    res_next.reused       = 1'b1;
                end
                else if (miss)
                begin
                    if (count_reg == CNT_W'(MAX_BLOCKS))
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else if (end_sum > END_W'(heap_limit))
                    begin
                        res_next.status = STAT_HEAP;
                    end
                    else
                    begin
                        ram_we                = 1'b1;
                        free_next[count_reg[IDX_W-1:0]] = 1'b0;
                        count_next            = count_reg + CNT_W'(1);
                        heap_top_next         = end_sum[HEAP_W-1:0];
                        res_next.block_handle = HANDLE_W'(count_reg[IDX_W-1:0]);
                        res_next.payload_addr = heap_top_reg[ADDR_W-1:0]
                                                + ADDR_W'(HEADER_BYTES);
                    end
                end
            end
            S_SEND:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            free_reg     <= '0;
            count_reg    <= '0;
            heap_top_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            free_reg     <= free_next;
            count_reg    <= count_next;
            heap_top_reg <= heap_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_size_reg <= req_size_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

endmodule

>>> src/first_fit_block_allocator_core.sv
// First-fit block allocator, top level: config register, result output stage.
// Depends on ffba_pkg and ffba_ctrl.
//
// Usage:
//   req channel (req_valid / req_stall / req): one beat is an allocate or a
//   free command. req_stall is high while a command is being worked on.
//   rsp channel (rsp_valid / rsp_stall / rsp): one beat per command. A result
//   sits in the output register until taken; the block meanwhile takes and
//   works the next command and holds its result until the register frees.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes heap_limit; write
//   only while idle. cfg_ready is always high.
// Timing: free and zero-size commands go from idle straight to the send
//   state and on to the output register. An allocate first scans the table
//   from entry 0, one table read per cycle, up to the first free entry k that
//   is large enough (reuse) or past all C blocks (append or fail); its result
//   then goes through the send state to the output register.
// The block takes one command at a time: req_stall stays high until the
//   result has left for the output register.
// Reset: empties the table, clears the bump pointer, sets heap_limit to its
//   maximum and drops rsp_valid. No clearing pass is needed.
module first_fit_block_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  ffba_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output ffba_pkg::rsp_t              rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0] cfg_data
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0] heap_limit_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;
    logic              slot_free;
    logic              busy;
    logic              res_valid;
    rsp_t              res;

    ffba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .heap_limit (heap_limit_reg),
        .slot_free  (slot_free),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = busy;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (slot_free)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= HEAP_LIMIT_RST;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                heap_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
